/* hw/rtl/mi3_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse unit.
package mi3_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned N_ELEM   = 9;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned CMAG_W   = 64;
  localparam int unsigned DET_W    = 97;
  localparam int unsigned DMAG_W   = 96;
  localparam int unsigned Q_BITS   = 32;
  localparam int unsigned NUM_W    = CMAG_W + Q_BITS;
  localparam int unsigned CMP_W    = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [DMAG_W-1:0]              dmag;
    logic                           dneg;
    logic                           sing;
    logic [N_ELEM-1:0][CMAG_W-1:0]  cmag;
    logic [N_ELEM-1:0]              cneg;
  } entry_t;

endpackage

/* hw/rtl/matrix3x3_inverse_unit.sv */
// Top level of the 3x3 matrix inverse unit.
// Takes one Q16.16 3x3 matrix per clock and returns its inverse and determinant,
// rounded to nearest (ties away from zero) and saturated to Q16.16; a zero
// determinant raises out_singular and zeroes everything else. Throughput is one
// item per cycle when the output is not stalled. With an empty queue, an item
// passes seven front-end stages that form the cofactors and the determinant,
// one queue entry, one set-up stage, a 32-stage restoring divider per inverse
// element (one quotient bit per stage), and the rounding/output register.
// The queue of QUEUE_DEPTH items lets the front end keep accepting while the
// output is stalled; in_stall rises when it fills.
module matrix3x3_inverse_unit #(
  parameter int unsigned QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mi3_pkg::elem_t  in_a00,
  input  mi3_pkg::elem_t  in_a01,
  input  mi3_pkg::elem_t  in_a02,
  input  mi3_pkg::elem_t  in_a10,
  input  mi3_pkg::elem_t  in_a11,
  input  mi3_pkg::elem_t  in_a12,
  input  mi3_pkg::elem_t  in_a20,
  input  mi3_pkg::elem_t  in_a21,
  input  mi3_pkg::elem_t  in_a22,
  output logic            out_valid,
  input  logic            out_stall,
  output mi3_pkg::elem_t  out_inv00,
  output mi3_pkg::elem_t  out_inv01,
  output mi3_pkg::elem_t  out_inv02,
  output mi3_pkg::elem_t  out_inv10,
  output mi3_pkg::elem_t  out_inv11,
  output mi3_pkg::elem_t  out_inv12,
  output mi3_pkg::elem_t  out_inv20,
  output mi3_pkg::elem_t  out_inv21,
  output mi3_pkg::elem_t  out_inv22,
  output mi3_pkg::elem_t  out_det_value,
  output logic            out_singular
);
  import mi3_pkg::*;

  elem_t   a_arr   [N_ELEM];
  elem_t   inv_arr [N_ELEM];
  logic    q_full;
  logic    push_valid;
  entry_t  push_entry;
  logic    head_valid;
  entry_t  head_entry;
  logic    pop;

  assign a_arr[0] = in_a00;
  assign a_arr[1] = in_a01;
  assign a_arr[2] = in_a02;
  assign a_arr[3] = in_a10;
  assign a_arr[4] = in_a11;
  assign a_arr[5] = in_a12;
  assign a_arr[6] = in_a20;
  assign a_arr[7] = in_a21;
  assign a_arr[8] = in_a22;

  assign out_inv00 = inv_arr[0];
  assign out_inv01 = inv_arr[1];
  assign out_inv02 = inv_arr[2];
  assign out_inv10 = inv_arr[3];
  assign out_inv11 = inv_arr[4];
  assign out_inv12 = inv_arr[5];
  assign out_inv20 = inv_arr[6];
  assign out_inv21 = inv_arr[7];
  assign out_inv22 = inv_arr[8];

  mi3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_a       (a_arr),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  mi3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mi3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_inv    (inv_arr),
    .out_det    (out_det_value),
    .out_sing   (out_singular)
  );

endmodule

/* hw/rtl/mi3_front.sv */
// Front end: accepts matrices, forms cofactors and determinant, classifies them.
module mi3_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mi3_pkg::elem_t   in_a [mi3_pkg::N_ELEM],
  input  logic             q_full,
  output logic             push_valid,
  output mi3_pkg::entry_t  push_entry
);
  import mi3_pkg::*;

  function automatic int nx(input int v);
    return (v == 2) ? 0 : v + 1;
  endfunction

  logic                       fe;
  logic [6:0]                 v_r;
  elem_t                      a_r  [N_ELEM];
  logic signed [PROD_W-1:0]   p_r  [N_ELEM];
  logic signed [PROD_W-1:0]   n_r  [N_ELEM];
  logic signed [PROD_W-1:0]   c_r  [N_ELEM];
  logic signed [PROD_W-1:0]   c3_r [N_ELEM];
  logic signed [PROD_W-1:0]   c4_r [N_ELEM];
  logic signed [PROD_W-1:0]   c5_r [N_ELEM];
  elem_t                      r1_r [3];
  elem_t                      r2_r [3];
  logic signed [PROD_W-1:0]   ph_r [3];
  logic signed [PROD_W:0]     pl_r [3];
  logic signed [DET_W-1:0]    t_r  [3];
  logic signed [DET_W-1:0]    det_r;
  logic signed [DET_W-1:0]    dabs;
  entry_t                     ent_nxt;
  entry_t                     ent_r;

  // The whole front holds while the queue is full.
  assign fe         = ~q_full;
  assign in_stall   = q_full;
  assign push_valid = v_r[6] & fe;
  assign push_entry = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_comb begin
    ent_nxt.sing = (det_r == '0);
    ent_nxt.dneg = det_r[DET_W-1];
    dabs         = det_r[DET_W-1] ? -det_r : det_r;
    ent_nxt.dmag = dabs[DMAG_W-1:0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // Inverse element (i,j) takes the cofactor of (j,i).
        ent_nxt.cneg[i*3+j] = c5_r[j*3+i][PROD_W-1];
        ent_nxt.cmag[i*3+j] = c5_r[j*3+i][PROD_W-1] ? CMAG_W'(-c5_r[j*3+i])
                                                     : CMAG_W'(c5_r[j*3+i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      a_r <= in_a;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i*3+j] <= a_r[nx(i)*3+nx(j)] * a_r[nx(nx(i))*3+nx(nx(j))];
          n_r[i*3+j] <= a_r[nx(i)*3+nx(nx(j))] * a_r[nx(nx(i))*3+nx(j)];
        end
      end
      for (int j = 0; j < 3; j++) begin
        r1_r[j] <= a_r[j];
        r2_r[j] <= r1_r[j];
        ph_r[j] <= r2_r[j] * $signed(c_r[j][PROD_W-1:32]);
        pl_r[j] <= r2_r[j] * $signed({1'b0, c_r[j][31:0]});
        t_r[j]  <= (DET_W'(ph_r[j]) <<< 32) + DET_W'(pl_r[j]);
      end
      for (int k = 0; k < N_ELEM; k++) begin
        c_r[k]  <= p_r[k] - n_r[k];
        c3_r[k] <= c_r[k];
        c4_r[k] <= c3_r[k];
        c5_r[k] <= c4_r[k];
      end
      det_r <= t_r[0] + t_r[1] + t_r[2];
      ent_r <= ent_nxt;
    end
  end

endmodule

/* hw/rtl/mi3_queue.sv */
// Short queue that decouples the front end from the divider back end.
module mi3_queue #(
  parameter int unsigned DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mi3_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output mi3_pkg::entry_t  head_entry
);
  import mi3_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t         mem_r [DEPTH];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rp_r];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

endmodule

/* hw/rtl/mi3_back.sv */
// Back end: pipelined restoring dividers, rounding, saturation and output register.
module mi3_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  mi3_pkg::entry_t  head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output mi3_pkg::elem_t   out_inv [mi3_pkg::N_ELEM],
  output mi3_pkg::elem_t   out_det,
  output logic             out_sing
);
  import mi3_pkg::*;

  localparam int unsigned LAST  = Q_BITS + 1;
  localparam int unsigned SAT_W = DMAG_W - Q_BITS + 1;
  localparam elem_t SAT_POS = elem_t'({1'b0, {(ELEM_W-1){1'b1}}});
  localparam elem_t SAT_NEG = elem_t'({1'b1, {(ELEM_W-1){1'b0}}});

  function automatic elem_t sat32(input logic neg, input logic ovf,
                                  input logic [SAT_W-1:0] mag);
    elem_t res;
    if (!neg) begin
      res = (ovf || mag > SAT_W'(SAT_POS)) ? SAT_POS : elem_t'(mag[ELEM_W-1:0]);
    end else begin
      res = (ovf || mag > SAT_W'(unsigned'(SAT_NEG))) ? SAT_NEG
                                                    : elem_t'(-mag[ELEM_W-1:0]);
    end
    return res;
  endfunction

  logic                     be;
  logic [LAST:0]            vb_r;
  logic [NUM_W-1:0]         rem_r  [Q_BITS+1][N_ELEM];
  logic [Q_BITS-1:0]        q_r    [Q_BITS+1][N_ELEM];
  logic [DMAG_W-1:0]        dmag_r [Q_BITS+1];
  logic                     dneg_r [Q_BITS+1];
  logic                     sing_r [Q_BITS+1];
  logic [N_ELEM-1:0]        cneg_r [Q_BITS+1];
  logic [N_ELEM-1:0]        ovf_r  [Q_BITS+1];
  logic [N_ELEM-1:0]        ovf_in;
  logic [NUM_W-1:0]         rem_nxt [1:Q_BITS][N_ELEM];
  logic                     ge_w    [1:Q_BITS][N_ELEM];
  elem_t                    inv_nxt [N_ELEM];
  elem_t                    det_nxt;
  elem_t                    inv_r   [N_ELEM];
  elem_t                    det_r;
  logic                     sing_out_r;

  // Everything advances together unless the output item is held.
  assign be        = ~(vb_r[LAST] & out_stall);
  assign pop       = be & head_valid;
  assign out_valid = vb_r[LAST];
  assign out_inv   = inv_r;
  assign out_det   = det_r;
  assign out_sing  = sing_out_r;

  // A quotient of 2^32 or more saturates whatever its sign.
  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      ovf_in[k] = CMP_W'({head_entry.cmag[k], {Q_BITS{1'b0}}})
                  >= (CMP_W'(head_entry.dmag) << Q_BITS);
    end
  end

  always_comb begin
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] diff;
    dsh  = '0;
    diff = '0;
    for (int s = 1; s <= Q_BITS; s++) begin
      for (int k = 0; k < N_ELEM; k++) begin
        dsh  = CMP_W'(dmag_r[s-1]) << (Q_BITS - s);
        diff = CMP_W'(rem_r[s-1][k]) - dsh;
        ge_w[s][k]    = CMP_W'(rem_r[s-1][k]) >= dsh;
        rem_nxt[s][k] = ge_w[s][k] ? diff[NUM_W-1:0] : rem_r[s-1][k];
      end
    end
  end

  always_comb begin
    logic                rnd;
    logic [Q_BITS:0]     qr;
    logic [DMAG_W:0]     dsum;
    rnd  = 1'b0;
    qr   = '0;
    for (int k = 0; k < N_ELEM; k++) begin
      rnd = {rem_r[Q_BITS][k], 1'b0} >= {1'b0, dmag_r[Q_BITS]};
      qr  = {1'b0, q_r[Q_BITS][k]} + (Q_BITS+1)'(rnd);
      inv_nxt[k] = sing_r[Q_BITS] ? '0
                 : sat32(cneg_r[Q_BITS][k] ^ dneg_r[Q_BITS], ovf_r[Q_BITS][k],
                         SAT_W'(qr));
    end
    dsum    = {1'b0, dmag_r[Q_BITS]} + (DMAG_W+1)'(33'h0_8000_0000);
    det_nxt = sing_r[Q_BITS] ? '0
            : sat32(dneg_r[Q_BITS], 1'b0, dsum[DMAG_W:Q_BITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (be) begin
      vb_r <= {vb_r[LAST-1:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      for (int k = 0; k < N_ELEM; k++) begin
        rem_r[0][k] <= {head_entry.cmag[k], {Q_BITS{1'b0}}};
        q_r[0][k]   <= '0;
      end
      dmag_r[0] <= head_entry.dmag;
      dneg_r[0] <= head_entry.dneg;
      sing_r[0] <= head_entry.sing;
      cneg_r[0] <= head_entry.cneg;
      ovf_r[0]  <= ovf_in;
      for (int s = 1; s <= Q_BITS; s++) begin
        for (int k = 0; k < N_ELEM; k++) begin
          rem_r[s][k] <= rem_nxt[s][k];
          q_r[s][k]   <= {q_r[s-1][k][Q_BITS-2:0], ge_w[s][k]};
        end
        dmag_r[s] <= dmag_r[s-1];
        dneg_r[s] <= dneg_r[s-1];
        sing_r[s] <= sing_r[s-1];
        cneg_r[s] <= cneg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
      end
      inv_r      <= inv_nxt;
      det_r      <= det_nxt;
      sing_out_r <= sing_r[Q_BITS];
    end
  end

endmodule

/* tb/tb_matrix3x3_inverse_unit.sv */
// Self-checking testbench for the 3x3 matrix inverse unit.
module tb_matrix3x3_inverse_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mi3_pkg::*;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
  } inverse_t;

  localparam int LATENCY   = 42;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  elem_t in_a [9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  elem_t out_inv [9];
  elem_t out_det_value;
  logic out_singular;
  logic in_stall_q = 1'b0;

  matrix_t pending_items[$];
  inverse_t expected_inverses[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int singular_seen = 0;
  longint cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  matrix3x3_inverse_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_det_value(out_det_value), .out_singular(out_singular)
  );

  // Apply the sign to an already rounded magnitude and saturate to Q16.16.
  function automatic elem_t round_saturate(logic [255:0] mag_q, logic neg);
    if (!neg) begin
      if (mag_q > 256'h7FFFFFFF) return 32'sh7FFFFFFF;
      return elem_t'(mag_q[31:0]);
    end
    if (mag_q > 256'h80000000) return 32'sh80000000;
    return elem_t'(-mag_q[31:0]);
  endfunction

  function automatic inverse_t invert_matrix(matrix_t m);
    inverse_t r;
    logic signed [63:0] cof [3][3];
    logic signed [127:0] det;
    logic [127:0] dmag;
    logic [255:0] num;
    logic [255:0] quo;
    logic [255:0] rem;
    logic dneg;
    int r0, r1, c0, c1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i + 1) % 3; r1 = (i + 2) % 3;
        c0 = (j + 1) % 3; c1 = (j + 2) % 3;
        cof[i][j] = 64'(m.a[r0*3+c0]) * 64'(m.a[r1*3+c1])
                  - 64'(m.a[r0*3+c1]) * 64'(m.a[r1*3+c0]);
      end
    end
    det = '0;
    for (int j = 0; j < 3; j++) det += 128'(m.a[j]) * 128'(cof[0][j]);
    r.sing = (det == 0);
    r.det = '0;
    for (int k = 0; k < 9; k++) r.inv[k] = '0;
    if (r.sing) return r;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    r.det = round_saturate((256'(dmag) + 256'h80000000) >> 32, dneg);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        num = 256'(cof[j][i] < 0 ? -cof[j][i] : cof[j][i]) << 32;
        quo = num / 256'(dmag);
        rem = num % 256'(dmag);
        if ((rem << 1) >= 256'(dmag)) quo++;
        r.inv[i*3+j] = round_saturate(quo, (cof[j][i] < 0) != dneg);
      end
    end
    return r;
  endfunction

  // Driver: presents queued matrices, holding each one while stalled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_q) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          matrix_t m;
          m = pending_items.pop_front();
          in_a <= m.a;
          expected_inverses.push_back(invert_matrix(m));
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Acceptance as seen at the last rising edge decides whether to advance.
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    cycle_count <= cycle_count + 1;
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      inverse_t e;
      logic bad;
      results_seen++;
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no matrix outstanding");
      end else begin
        e = expected_inverses.pop_front();
        bad = (out_det_value !== e.det) || (out_singular !== e.sing);
        for (int k = 0; k < 9; k++) if (out_inv[k] !== e.inv[k]) bad = 1'b1;
        if (e.sing) singular_seen++;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: det exp %h got %h, singular exp %b got %b",
                     e.det, out_det_value, e.sing, out_singular);
            for (int k = 0; k < 9; k++)
              $display("  inv[%0d] exp %h got %h", k, e.inv[k], out_inv[k]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic elem_t random_element();
    case ($urandom_range(5))
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(131072)) - 32'sd65536;
      2: return elem_t'($urandom_range(8)) <<< 16;
      3: return -(elem_t'($urandom_range(8)) <<< 16);
      4: return elem_t'($urandom_range(16)) - 32'sd8;
      default: return elem_t'($urandom_range(33554432)) - 32'sd16777216;
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    for (int k = 0; k < 9; k++) m.a[k] = random_element();
    kind = $urandom_range(9);
    // Copied rows or columns, or a zeroed row, make the determinant exactly zero.
    if (kind == 0) for (int j = 0; j < 3; j++) m.a[6+j] = m.a[j];
    if (kind == 1) for (int i = 0; i < 3; i++) m.a[i*3+2] = m.a[i*3];
    if (kind == 2) for (int j = 0; j < 3; j++) m.a[3+j] = '0;
    return m;
  endfunction

  task automatic add_directed();
    matrix_t m;
    elem_t vals [4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sh00000001};
    // Identity, then uniform matrices at the extremes, one and one LSB (singular).
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 32'sh00010000 : '0;
    pending_items.push_back(m);
    foreach (vals[v]) begin
      foreach (m.a[k]) m.a[k] = vals[v];
      pending_items.push_back(m);
    end
    // Diagonal extremes: huge and tiny determinants, saturating inverses.
    foreach (vals[v]) begin
      foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? vals[v] : '0;
      pending_items.push_back(m);
      foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? -vals[v] : '0;
      pending_items.push_back(m);
    end
    // A permutation matrix with determinant one but not symmetric.
    foreach (m.a[k]) m.a[k] = '0;
    m.a[1] = 32'sh00010000; m.a[5] = 32'sh00010000; m.a[6] = 32'sh00010000;
    pending_items.push_back(m);
    // Determinant of one with a non-orthogonal matrix.
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 32'sh00010000 : '0;
    m.a[1] = 32'sh00020000; m.a[5] = 32'sh00030000;
    pending_items.push_back(m);
    // Alternating extremes, all zero and all minus one LSB.
    foreach (m.a[k]) m.a[k] = (k % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
    pending_items.push_back(m);
    foreach (m.a[k]) m.a[k] = '0;
    pending_items.push_back(m);
    foreach (m.a[k]) m.a[k] = 32'shFFFFFFFF;
    pending_items.push_back(m);
  endtask

  task automatic run_phase(int items, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) pending_items.push_back(random_matrix());
    while (pending_items.size() > 0 || expected_inverses.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    add_directed();
    run_phase(350, 0, 0);
    run_phase(350, 57, 0);
    run_phase(350, 0, 57);
    run_phase(350, 23, 23);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results (%0d singular) under four idle and stall mixes.",
             results_seen, singular_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
